// ===== design/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/ltc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ltc_pkg;

   localparam int LBA_W     = 13;
   localparam int COUNT_W   = 10;
   localparam int SPT_W     = 6;
   localparam int PCYL_W    = 7;
   localparam int CYL_W     = 7;
   localparam int SEG_W     = 6;
   localparam int RES_CNT_W = 6;

   localparam int MAX_RESULTS = 58;

   localparam logic [SPT_W-1:0] SPT_SMALL = 6'd18;
   localparam logic [SPT_W-1:0] SPT_LARGE = 6'd36;

   typedef enum logic [1:0] {
      STATUS_SEGMENT = 2'd0,
      STATUS_REJECT  = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_LOCATE,
      ST_SEGMENT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== design/lba_track_chunker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// channel   direction  handshake             payload
// req_      in         req_tvalid/tready     tuser op, tdata start_block/block_count
// rsp_      out        rsp_tvalid/tready     tuser status/is_write, tdata segment, tlast
// csr_      in         csr_we                csr_wdata track_sectors
//
// a request is taken only in idle; the next one is taken after the final result is taken
// rejected and empty requests go from the check state straight to the result state
// a segment request runs the divide, locate and segment states to its first result;
// the 13-step restoring divider splits the block address by sectors per cylinder
// each further segment passes the segment state again while rsp_tready stays high;
// a low rsp_tready holds the result register and the sequencer
// reset is synchronous; sectors-per-track clears to 0 (every request rejected)

module lba_track_chunker
   import ltc_pkg::*;
#(
   parameter int MAX_SEGMENT = 36,
   parameter int CYLINDERS   = 80,
   parameter int HEAD_COUNT  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [23:0]       req_tdata,   // start_block[12:0], block_count[22:13]
   input  wire logic              req_tuser,   // op
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [23:0]       rsp_tdata,   // cylinder[6:0], head_sel[7],
                                               // first_sector[13:8], segment_len[19:14]
   output logic      [2:0]        rsp_tuser,   // status[1:0], is_write[2]
   output logic                   rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [SPT_W-1:0]  csr_wdata
);

   localparam int   DISK_W   = PCYL_W + $clog2(CYLINDERS + 1);
   localparam int   CHK_W    = ((DISK_W > LBA_W) ? DISK_W : LBA_W) + 1;
   localparam logic ONE_HEAD = (HEAD_COUNT == 1);
   localparam logic [COUNT_W-1:0] MAX_SEG_C = COUNT_W'(MAX_SEGMENT);

   state_type              state_ff, state_in;
   logic [SPT_W-1:0]       spt_ff;

   logic                   op_ff, op_in;
   logic [LBA_W-1:0]       lba_ff, lba_in;
   logic [COUNT_W-1:0]     remain_ff, remain_in;
   logic [DISK_W-1:0]      disk_ff, disk_in;
   logic [LBA_W-1:0]       cyl_ff, cyl_in;
   logic                   head_ff, head_in;
   logic [SPT_W-1:0]       sec_ff, sec_in;
   logic [SEG_W-1:0]       cnt_ff, cnt_in;
   logic [RES_CNT_W-1:0]   res_cnt_ff, res_cnt_in;

   status_type             status_ff, status_in;
   logic [CYL_W-1:0]       cyl_out_ff, cyl_out_in;
   logic                   head_out_ff, head_out_in;
   logic [SEG_W-1:0]       first_ff, first_in;
   logic [SEG_W-1:0]       len_ff, len_in;
   logic                   last_ff, last_in;

   logic [PCYL_W-1:0]      per_cyl;
   logic [DISK_W-1:0]      disk_prod;
   logic                   reject;
   logic                   empty;
   logic [COUNT_W-1:0]     avail;
   logic [COUNT_W-1:0]     cnt_min;
   logic [COUNT_W-1:0]     cnt_calc;
   logic [SEG_W-1:0]       seg_len;
   logic                   seg_last;
   logic [SPT_W:0]         sec_sum;
   logic                   track_end;
   logic                   req_accept;
   logic                   div_start;
   div_status_type         div_status;
   logic [LBA_W-1:0]       div_quo;
   logic [PCYL_W-1:0]      div_rem;
   logic                   loc_head;

   ltc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lba_ff),
      .divisor   (per_cyl),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff <= '0;
      end else if (csr_we) begin
         spt_ff <= (csr_wdata == SPT_SMALL || csr_wdata == SPT_LARGE) ? csr_wdata : '0;
      end
   end

   always_comb begin
      per_cyl   = ONE_HEAD ? {1'b0, spt_ff} : {spt_ff, 1'b0};
      disk_prod = DISK_W'(per_cyl) * DISK_W'(CYLINDERS);
      reject    = (spt_ff == '0) ||
                  (CHK_W'(lba_ff) > CHK_W'(disk_ff)) ||
                  (CHK_W'(remain_ff) > (CHK_W'(disk_ff) - CHK_W'(lba_ff)));
      empty     = (remain_ff == '0);
      avail     = COUNT_W'(spt_ff - sec_ff);
      cnt_min   = (avail < remain_ff) ? avail : remain_ff;
      cnt_calc  = (cnt_min > MAX_SEG_C) ? MAX_SEG_C : cnt_min;
      seg_len   = cnt_calc[SEG_W-1:0];
      seg_last  = (remain_ff == COUNT_W'(seg_len)) ||
                  (res_cnt_ff == RES_CNT_W'(MAX_RESULTS - 1));
      sec_sum   = {1'b0, sec_ff} + (SPT_W + 1)'(cnt_ff);
      track_end = (sec_sum == {1'b0, spt_ff});
      loc_head  = (div_rem >= {1'b0, spt_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK:   state_in = (reject || empty) ? ST_RESULT : ST_DIVIDE;
         ST_DIVIDE:  if (div_status.done) state_in = ST_LOCATE;
         ST_LOCATE:  state_in = ST_SEGMENT;
         ST_SEGMENT: state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_tready) state_in = last_ff ? ST_IDLE : ST_SEGMENT;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_CHECK:   div_start  = !reject && !empty;
         ST_RESULT:  rsp_tvalid = 1'b1;
         ST_DIVIDE, ST_LOCATE, ST_SEGMENT: begin
         end
         default: begin
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   // datapath
   always_comb begin
      op_in       = op_ff;
      lba_in      = lba_ff;
      remain_in   = remain_ff;
      disk_in     = disk_ff;
      cyl_in      = cyl_ff;
      head_in     = head_ff;
      sec_in      = sec_ff;
      cnt_in      = cnt_ff;
      res_cnt_in  = res_cnt_ff;
      status_in   = status_ff;
      cyl_out_in  = cyl_out_ff;
      head_out_in = head_out_ff;
      first_in    = first_ff;
      len_in      = len_ff;
      last_in     = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_tuser;
               lba_in     = req_tdata[LBA_W-1:0];
               remain_in  = req_tdata[LBA_W+COUNT_W-1:LBA_W];
               disk_in    = disk_prod;
               res_cnt_in = '0;
            end
         end
         ST_CHECK: begin
            if (reject || empty) begin
               status_in   = reject ? STATUS_REJECT : STATUS_EMPTY;
               cyl_out_in  = '0;
               head_out_in = 1'b0;
               first_in    = '0;
               len_in      = '0;
               last_in     = 1'b1;
            end
         end
         ST_LOCATE: begin
            cyl_in  = div_quo;
            head_in = loc_head;
            sec_in  = loc_head ? SPT_W'(div_rem - {1'b0, spt_ff}) : div_rem[SPT_W-1:0];
         end
         ST_SEGMENT: begin
            status_in   = STATUS_SEGMENT;
            cyl_out_in  = cyl_ff[CYL_W-1:0];
            head_out_in = head_ff;
            first_in    = sec_ff + 1'b1;
            len_in      = seg_len;
            last_in     = seg_last;
            cnt_in      = seg_len;
         end
         ST_RESULT: begin
            if (rsp_tready && !last_ff) begin
               remain_in  = remain_ff - COUNT_W'(cnt_ff);
               res_cnt_in = res_cnt_ff + 1'b1;
               sec_in     = track_end ? '0 : sec_sum[SPT_W-1:0];
               // step to the next track, then the next cylinder
               if (track_end) begin
                  if (ONE_HEAD || head_ff) begin
                     head_in = 1'b0;
                     cyl_in  = cyl_ff + 1'b1;
                  end else begin
                     head_in = 1'b1;
                  end
               end
            end
         end
         ST_DIVIDE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lba_ff      <= lba_in;
      remain_ff   <= remain_in;
      disk_ff     <= disk_in;
      cyl_ff      <= cyl_in;
      head_ff     <= head_in;
      sec_ff      <= sec_in;
      cnt_ff      <= cnt_in;
      res_cnt_ff  <= res_cnt_in;
      status_ff   <= status_in;
      cyl_out_ff  <= cyl_out_in;
      head_out_ff <= head_out_in;
      first_ff    <= first_in;
      len_ff      <= len_in;
      last_ff     <= last_in;
   end

   assign rsp_tdata = {4'b0000, len_ff, first_ff, head_out_ff, cyl_out_ff};
   assign rsp_tuser = {op_ff, status_ff};
   assign rsp_tlast = last_ff;

   `ASSERT_CHECK(a_seg_in_track, clock, reset, (rsp_tvalid && status_ff == STATUS_SEGMENT) |-> (len_ff != '0 && first_ff != '0 && (7'(first_ff) + 7'(len_ff)) <= (7'(spt_ff) + 7'd1)), "segment leaves its track")
   `ASSERT_CHECK(a_nonseg_last, clock, reset, (rsp_tvalid && status_ff != STATUS_SEGMENT) |-> (last_ff && len_ff == '0), "non-segment result not final")
   `ASSERT_CHECK(a_result_cap, clock, reset, rsp_tvalid |-> (res_cnt_ff < RES_CNT_W'(MAX_RESULTS)), "too many results for one request")
   `ASSERT_CHECK(a_div_owned, clock, reset, div_status.busy |-> (state_ff == ST_DIVIDE), "divider running outside divide state")

endmodule

`default_nettype wire

// ===== design/ltc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ltc_divider
   import ltc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [LBA_W-1:0]    dividend,
   input  wire logic [PCYL_W-1:0]   divisor,
   output div_status_type           status,
   output logic      [LBA_W-1:0]    quotient,
   output logic      [PCYL_W-1:0]   remainder
);

   localparam int STEP_W = $clog2(LBA_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [LBA_W-1:0]    quo_ff, quo_in;
   logic [PCYL_W-1:0]   rem_ff, rem_in;
   logic [PCYL_W:0]     shifted;
   logic [PCYL_W:0]     diff;
   logic                fits;

   // one restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      shifted = {rem_ff, quo_ff[LBA_W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[LBA_W-2:0], fits};
         rem_in  = fits ? diff[PCYL_W-1:0] : shifted[PCYL_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(LBA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

   `ASSERT_NEVER(a_start_busy, clock, reset, start && busy_ff, "divider started while busy")
   `ASSERT_NEVER(a_done_busy, clock, reset, done_ff && busy_ff, "divider done while still busy")
   `ASSERT_CHECK(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without a run")

endmodule

`default_nettype wire
